[src/sact_pkg.sv]
`timescale 1ns / 1ps

package sact_pkg;

  // geometry of the tag store
  localparam int NUM_SETS  = 64;
  localparam int NUM_WAYS  = 4;
  localparam int TAG_WIDTH = 52;

  // fixed field widths of the channels
  localparam int OP_W     = 3;
  localparam int SET_W    = 6;
  localparam int WAY_W    = 2;
  localparam int TAG_IN_W = 52;

  // derived sizes
  localparam int ENTRIES = NUM_SETS * NUM_WAYS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SIDX_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd0;
  localparam logic [OP_W-1:0] OP_INV_WAY  = 3'd1;
  localparam logic [OP_W-1:0] OP_INV_ADDR = 3'd2;
  localparam logic [OP_W-1:0] OP_INV_ALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd4;

  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [SIDX_W-1:0]    sidx_t;
  typedef logic [NUM_WAYS-1:0]  vword_t;

endpackage

[src/sact_if.sv]
`timescale 1ns / 1ps

// request channel: one operation word
interface sact_in_if;
  import sact_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SET_W-1:0]    set_sel;
  logic [WAY_W-1:0]    way_sel;
  logic [TAG_IN_W-1:0] tag_in;

  modport source (output valid, op, set_sel, way_sel, tag_in, input ready);
  modport sink   (input valid, op, set_sel, way_sel, tag_in, output ready);
endinterface

// response channel: one result word
interface sact_out_if;
  import sact_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] hit_way;

  modport source (output valid, hit, hit_way, input ready);
  modport sink   (input valid, hit, hit_way, output ready);
endinterface

[src/sact_ram.sv]
`timescale 1ns / 1ps

module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[src/sact_way_cmp.sv]
`timescale 1ns / 1ps

module sact_way_cmp
  import sact_pkg::*;
(
  input  logic entry_valid,
  input  tag_t entry_tag,
  input  tag_t ref_tag,
  output logic match
);

  // one way matches when it holds a valid copy of the tag
  assign match = entry_valid && (entry_tag == ref_tag);

endmodule

[src/set_assoc_cache_tag_store.sv]
`timescale 1ns / 1ps

// Tag store of a set-associative cache, NUM_SETS sets by NUM_WAYS ways, with
// a valid bit and a TAG_WIDTH-bit tag per entry. Tags sit in a single-port
// RAM, the valid bits of a set sit together in one word of a second
// single-port RAM, and one tag comparator is shared across the ways. The
// set's valid word is read as the request is taken; a lookup or an
// invalidate-by-address then reads and compares one way at a time, a read
// state and then a compare state per way, lowest way first, and stops at the
// first hit; then the result is posted. Invalidate by set/way and load do one
// read-modify-write on the valid word and then post the result.
// Invalidate-all walks every set and clears its valid word, then posts the
// result. After reset the same walk clears the valid words with the request
// side not ready. A new request is taken only while no operation is in
// flight; a finished result may still wait in the output register. Every
// request returns one response word: hit and the lowest matching way for
// lookups and invalidates by address, a miss for all other operations.
module set_assoc_cache_tag_store
  import sact_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sact_in_if.sink    in_ch,
  sact_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_RESP  = 3'd3;
  localparam logic [2:0] ST_VGET  = 3'd4;
  localparam logic [2:0] ST_INIT  = 3'd5;
  localparam logic [2:0] ST_CLEAR = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sidx_t            clr_r, clr_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [WAY_W-1:0] way_r, way_nxt;
  tag_t             tag_r, tag_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic [WAY_W-1:0] res_way_r, res_way_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [WAY_W-1:0] out_way_r, out_way_nxt;

  logic   accept;
  logic   in_set_ok;
  logic   in_way_ok;
  logic   need_vrd;
  tag_t   in_tag;
  idx_t   in_idx;
  idx_t   walk_idx;
  logic   ram_en;
  logic   ram_we;
  idx_t   ram_addr;
  tag_t   ram_rdata;
  logic   vram_en;
  logic   vram_we;
  sidx_t  vram_addr;
  vword_t vram_wdata;
  vword_t vram_rdata;
  vword_t way_bit;
  vword_t cnt_bit;
  logic   match;
  logic   last_way;
  logic   last_set;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.hit     = out_hit_r;
  assign out_ch.hit_way = out_way_r;

  // request decode
  assign in_set_ok = 32'(in_ch.set_sel) < NUM_SETS;
  assign in_way_ok = 32'(in_ch.way_sel) < NUM_WAYS;
  assign in_tag    = TAG_WIDTH'(in_ch.tag_in);
  assign in_idx    = IDX_W'(32'(in_ch.set_sel) * NUM_WAYS + 32'(in_ch.way_sel));
  assign walk_idx  = IDX_W'(32'(set_r) * NUM_WAYS + 32'(cnt_r));
  assign last_way  = 32'(cnt_r) == NUM_WAYS - 1;
  assign last_set  = 32'(clr_r) == NUM_SETS - 1;
  assign way_bit   = vword_t'(1) << way_r;
  assign cnt_bit   = vword_t'(1) << cnt_r;

  // requests that need the valid word of their set
  assign need_vrd = in_set_ok &&
                    ((in_ch.op inside {OP_LOOKUP, OP_INV_ADDR}) ||
                     ((in_ch.op inside {OP_INV_WAY, OP_LOAD}) && in_way_ok));

  // tag ram port: write on load, read while walking the ways
  assign ram_we   = accept && (in_ch.op == OP_LOAD) && in_set_ok && in_way_ok;
  assign ram_en   = ram_we || (state_r == ST_READ);
  assign ram_addr = ram_we ? in_idx : walk_idx;

  sact_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tag),
    .rdata (ram_rdata)
  );

  // valid ram port: read on accept, read-modify-write, clearing walk
  always_comb begin
    vram_en    = 1'b0;
    vram_we    = 1'b0;
    vram_addr  = SIDX_W'(set_r);
    vram_wdata = '0;
    case (state_r)
      ST_IDLE: begin
        vram_en   = accept && need_vrd;
        vram_addr = SIDX_W'(in_ch.set_sel);
      end
      ST_INIT, ST_CLEAR: begin
        vram_en   = 1'b1;
        vram_we   = 1'b1;
        vram_addr = clr_r;
      end
      ST_VGET: begin
        vram_en = 1'b1;
        vram_we = 1'b1;
        if (op_r == OP_LOAD) begin
          vram_wdata = vram_rdata | way_bit;
        end else begin
          vram_wdata = vram_rdata & ~way_bit;
        end
      end
      ST_CMP: begin
        vram_en    = match && (op_r == OP_INV_ADDR);
        vram_we    = vram_en;
        vram_wdata = vram_rdata & ~cnt_bit;
      end
      default: ;
    endcase
  end

  sact_ram #(
    .WIDTH (NUM_WAYS),
    .DEPTH (NUM_SETS)
  ) u_valid_ram (
    .clk   (clk),
    .en    (vram_en),
    .we    (vram_we),
    .addr  (vram_addr),
    .wdata (vram_wdata),
    .rdata (vram_rdata)
  );

  // shared tag comparator
  sact_way_cmp u_cmp (
    .entry_valid (vram_rdata[cnt_r]),
    .entry_tag   (ram_rdata),
    .ref_tag     (tag_r),
    .match       (match)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    set_nxt       = set_r;
    way_nxt       = way_r;
    tag_nxt       = tag_r;
    res_hit_nxt   = res_hit_r;
    res_way_nxt   = res_way_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_way_nxt   = out_way_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt      = in_ch.op;
          set_nxt     = in_ch.set_sel;
          way_nxt     = in_ch.way_sel;
          tag_nxt     = in_tag;
          cnt_nxt     = '0;
          res_hit_nxt = 1'b0;
          res_way_nxt = '0;
          state_nxt   = ST_RESP;
          if (in_ch.op inside {OP_LOOKUP, OP_INV_ADDR}) begin
            if (in_set_ok) begin
              state_nxt = ST_READ;
            end
          end else if (in_ch.op inside {OP_INV_WAY, OP_LOAD}) begin
            if (in_set_ok && in_way_ok) begin
              state_nxt = ST_VGET;
            end
          end else if (in_ch.op == OP_INV_ALL) begin
            clr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_VGET: begin
        state_nxt = ST_RESP;
      end
      ST_INIT: begin
        if (last_set) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_CLEAR: begin
        if (last_set) begin
          state_nxt = ST_RESP;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (match) begin
          res_hit_nxt = 1'b1;
          res_way_nxt = WAY_W'(cnt_r);
          state_nxt   = ST_RESP;
        end else if (last_way) begin
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_RESP: begin
        // post the result once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_way_nxt   = res_way_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    op_r      <= op_nxt;
    set_r     <= set_nxt;
    way_r     <= way_nxt;
    tag_r     <= tag_nxt;
    res_hit_r <= res_hit_nxt;
    res_way_r <= res_way_nxt;
    out_hit_r <= out_hit_nxt;
    out_way_r <= out_way_nxt;
  end

endmodule

[tb/sv/tb_set_assoc_cache_tag_store.sv]
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_store;
  import sact_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } resp_t;

  logic clk;
  logic rst_n;

  sact_in_if  in_ch();
  sact_out_if out_ch();

  set_assoc_cache_tag_store dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the tag array
  logic  store_valid [ENTRIES];
  tag_t  store_tag   [ENTRIES];
  resp_t expected_resp[$];

  // small set of recurring tags so that ways alias and lookups hit
  logic [TAG_IN_W-1:0] tag_pool[8];

  bit stall_en;
  int words_sent;
  int words_checked;
  int hits_seen;
  int err_cnt;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_en && $urandom_range(99) < 26)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= 1'b1;
  end

  // work out the response for one operation and update the shadow array
  function automatic resp_t predict_and_update(logic [OP_W-1:0] op, logic [SET_W-1:0] s,
                                               logic [WAY_W-1:0] w,
                                               logic [TAG_IN_W-1:0] t);
    resp_t r;
    int    base;
    tag_t  tg;
    r    = '0;
    base = int'(s) * NUM_WAYS;
    tg   = t[TAG_WIDTH-1:0];
    case (op)
      OP_LOOKUP, OP_INV_ADDR: begin
        // scan downward so the lowest matching way wins
        if (int'(s) < NUM_SETS) begin
          for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (store_valid[base + i] && store_tag[base + i] == tg) begin
              r.hit = 1'b1;
              r.way = WAY_W'(i);
            end
          end
        end
        if (op == OP_INV_ADDR && r.hit)
          store_valid[base + int'(r.way)] = 1'b0;
      end
      OP_INV_WAY: begin
        if (int'(s) < NUM_SETS && int'(w) < NUM_WAYS)
          store_valid[base + int'(w)] = 1'b0;
      end
      OP_INV_ALL: begin
        for (int i = 0; i < ENTRIES; i++)
          store_valid[i] = 1'b0;
      end
      OP_LOAD: begin
        if (int'(s) < NUM_SETS && int'(w) < NUM_WAYS) begin
          store_tag[base + int'(w)]   = tg;
          store_valid[base + int'(w)] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [TAG_IN_W-1:0] rand_tag();
    return TAG_IN_W'({$urandom, $urandom});
  endfunction

  // send one request word and record its expected response
  task automatic send_word(logic [OP_W-1:0] op, logic [SET_W-1:0] s,
                           logic [WAY_W-1:0] w, logic [TAG_IN_W-1:0] t);
    while (stall_en && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.set_sel <= s;
    in_ch.way_sel <= w;
    in_ch.tag_in  <= t;
    do @(posedge clk); while (!in_ch.ready);
    expected_resp.push_back(predict_and_update(op, s, w, t));
    words_sent++;
  endtask

  // response checker
  always @(posedge clk) begin
    resp_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (out_ch.hit)
        hits_seen++;
      if (expected_resp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: response word with nothing pending: hit=%0b way=%0d",
                   $realtime, out_ch.hit, out_ch.hit_way);
      end else begin
        exp_r = expected_resp.pop_front();
        if (out_ch.hit !== exp_r.hit || out_ch.hit_way !== exp_r.way) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: mismatch: expected hit=%0b way=%0d, got hit=%0b way=%0d",
                     $realtime, exp_r.hit, exp_r.way, out_ch.hit, out_ch.hit_way);
        end
      end
    end
  end

  // corners: empty array, extreme sets and tags, aliasing ways, every op
  task automatic test_directed_corners();
    logic [TAG_IN_W-1:0] ones;
    ones = '1;
    send_word(OP_LOOKUP,   6'd0,  2'd0, '0);
    send_word(OP_LOAD,     6'd63, 2'd3, ones);
    send_word(OP_LOOKUP,   6'd63, 2'd0, ones);
    send_word(OP_LOAD,     6'd63, 2'd1, ones);
    send_word(OP_LOOKUP,   6'd63, 2'd2, ones);
    send_word(OP_LOAD,     6'd0,  2'd0, '0);
    send_word(OP_LOOKUP,   6'd0,  2'd3, '0);
    // overwrite a valid way with a new tag
    send_word(OP_LOAD,     6'd63, 2'd1, 52'h5_5555_5555_5555);
    send_word(OP_LOOKUP,   6'd63, 2'd0, ones);
    send_word(OP_LOOKUP,   6'd63, 2'd0, 52'h5_5555_5555_5555);
    send_word(OP_INV_WAY,  6'd63, 2'd3, ones);
    send_word(OP_LOOKUP,   6'd63, 2'd0, ones);
    // invalidating an empty way does nothing
    send_word(OP_INV_WAY,  6'd5,  2'd2, '0);
    send_word(OP_INV_ADDR, 6'd63, 2'd0, 52'hA_AAAA_AAAA_AAAA);
    send_word(OP_INV_ADDR, 6'd63, 2'd3, 52'h5_5555_5555_5555);
    send_word(OP_LOOKUP,   6'd63, 2'd0, 52'h5_5555_5555_5555);
    // undefined ops leave the array alone
    send_word(3'd5,        6'd0,  2'd0, '0);
    send_word(3'd6,        6'd63, 2'd3, ones);
    send_word(3'd7,        6'd0,  2'd0, '0);
    send_word(OP_LOOKUP,   6'd0,  2'd0, '0);
    send_word(OP_INV_ALL,  6'd63, 2'd3, ones);
    send_word(OP_LOOKUP,   6'd0,  2'd0, '0);
  endtask

  // weighted random mix that keeps sets populated so lookups hit often
  task automatic test_random_ops(int n_words);
    logic [OP_W-1:0]     op;
    logic [SET_W-1:0]    s;
    logic [WAY_W-1:0]    w;
    logic [TAG_IN_W-1:0] t;
    int                  pick;
    for (int k = 0; k < n_words; k++) begin
      pick = $urandom_range(999);
      if (pick < 350)      op = OP_LOOKUP;
      else if (pick < 450) op = OP_INV_WAY;
      else if (pick < 600) op = OP_INV_ADDR;
      else if (pick < 615) op = OP_INV_ALL;
      else if (pick < 950) op = OP_LOAD;
      else                 op = OP_W'($urandom_range(7, 5));
      s = ($urandom_range(99) < 70) ? SET_W'($urandom_range(3)) : SET_W'($urandom);
      w = WAY_W'($urandom);
      if (op == OP_LOOKUP || op == OP_INV_ADDR) begin
        // mostly probe with a tag that sits in the set
        if ($urandom_range(99) < 65)
          t = store_tag[int'(s) * NUM_WAYS + $urandom_range(NUM_WAYS - 1)];
        else if ($urandom_range(1))
          t = tag_pool[$urandom_range(7)];
        else
          t = rand_tag();
      end else begin
        t = ($urandom_range(99) < 40) ? tag_pool[$urandom_range(7)] : rand_tag();
      end
      send_word(op, s, w, t);
    end
  endtask

  // back-to-back traffic with no gaps on either side
  task automatic test_burst_no_stall(int n_words);
    stall_en = 1'b0;
    test_random_ops(n_words);
    stall_en = 1'b1;
  endtask

  task automatic drain_and_report();
    in_ch.valid <= 1'b0;
    while (expected_resp.size() != 0)
      @(posedge clk);
    repeat (4 * NUM_WAYS + 8) @(posedge clk);
    $display("sent %0d request words, checked %0d response words (%0d hits)",
             words_sent, words_checked, hits_seen);
    $display("covered lookups, loads, all invalidate forms and undefined ops, %0d errors",
             err_cnt + expected_resp.size());
    if (err_cnt == 0 && expected_resp.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      store_valid[i] = 1'b0;
      store_tag[i]   = '0;
    end
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++)
      tag_pool[i] = rand_tag();
    stall_en      = 1'b1;
    words_sent    = 0;
    words_checked = 0;
    hits_seen     = 0;
    err_cnt       = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OP_LOOKUP;
    in_ch.set_sel <= '0;
    in_ch.way_sel <= '0;
    in_ch.tag_in  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_ops(600);
    test_burst_no_stall(400);
    test_random_ops(330);
    drain_and_report();
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
